@@ rtl/rtt_pkg.sv @@
package rtt_pkg;

   localparam int SLOTS_DEFAULT = 8;
   localparam int MAX_BURST     = 8;
   localparam int QUEUE_DEPTH   = 2;
   localparam int REQ_DATA_W    = 40;
   localparam int RSP_DATA_W    = 40;
   localparam int TIMEOUT_W     = 31;
   localparam int TIME_W        = 32;
   localparam int TAG_W         = 16;

   localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 31'd20000;
   localparam logic [7:0]           NONHOST_MASK  = 8'hC0;

   typedef enum logic [1:0] {
      ACT_REQUEST  = 2'd0,
      ACT_RESPONSE = 2'd1,
      ACT_TICK     = 2'd2
   } action_type;

   typedef enum logic [1:0] {
      KIND_OUTCOME   = 2'd0,
      KIND_DELIVERED = 2'd1,
      KIND_DISCARDED = 2'd2,
      KIND_TIMEOUT   = 2'd3
   } kind_type;

   // decoded item handed from front to back
   typedef struct packed {
      action_type       op;
      logic             bcast;
      logic             track;
      logic             sent;
      logic [TAG_W-1:0] tag;
      logic             matchable;
      logic             host;
      logic [6:0]       seq;
      logic [7:0]       status;
   } cmd_type;

   typedef struct packed {
      logic    valid;
      cmd_type cmd;
   } queue_out_type;

endpackage

@@ rtl/rtt_front.sv @@
module rtt_front
   import rtt_pkg::*;
(
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,
   input  logic [1:0]            req_tuser,
   input  logic                  q_full,
   output logic                  q_push,
   output cmd_type               q_cmd
);

   logic known;

   always_comb begin
      q_cmd.op        = ACT_REQUEST;
      known           = 1'b1;
      unique case (req_tuser)
         ACT_REQUEST:  q_cmd.op = ACT_REQUEST;
         ACT_RESPONSE: q_cmd.op = ACT_RESPONSE;
         ACT_TICK:     q_cmd.op = ACT_TICK;
         default:      known = 1'b0;
      endcase
      q_cmd.bcast     = req_tdata[0];
      q_cmd.track     = req_tdata[1];
      q_cmd.sent      = req_tdata[2];
      q_cmd.tag       = req_tdata[18:3];
      // sequence bytes 0x80 and above never hit a slot
      q_cmd.matchable = req_tdata[19] & ~req_tdata[27];
      q_cmd.host      = (req_tdata[27:20] & NONHOST_MASK) == 8'h00;
      q_cmd.seq       = req_tdata[26:20];
      q_cmd.status    = req_tdata[35:28];
   end

   assign req_tready = ~q_full;
   assign q_push     = req_tvalid & ~q_full & known;

endmodule

@@ rtl/rtt_queue.sv @@
module rtt_queue
   import rtt_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          push,
   input  cmd_type       push_cmd,
   output logic          full,
   output queue_out_type head,
   input  logic          pop
);

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   cmd_type              entry_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic                 do_push, do_pop;

   assign full       = count_ff == CNT_W'(QUEUE_DEPTH);
   assign head.valid = count_ff != '0;
   assign head.cmd   = entry_ff[rd_ptr_ff];
   assign do_push    = push & ~full;
   assign do_pop     = pop & head.valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push & ~do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop & ~do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

@@ rtl/rtt_back.sv @@
module rtt_back
   import rtt_pkg::*;
#(
   parameter int SLOTS = SLOTS_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_wen,
   input  logic [TIMEOUT_W-1:0]  csr_wdata,
   input  queue_out_type         head,
   output logic                  q_pop,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   output logic [1:0]            rsp_tuser,
   output logic                  rsp_tlast
);

   localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int CNT_W  = (MAX_BURST > 1) ? $clog2(MAX_BURST) : 1;

   typedef enum logic [2:0] {
      ST_IDLE  = 3'b001,
      ST_SCAN  = 3'b010,
      ST_DRAIN = 3'b100
   } state_type;

   state_type             state_ff, state_in;
   logic [SLOTS-1:0]      active_ff, active_in;
   logic [SLOTS-1:0]      mask_ff, mask_in;
   logic [SLOT_W-1:0]     idx_ff, idx_in;
   logic [CNT_W-1:0]      cnt_ff, cnt_in;
   logic [5:0]            counter_ff, counter_in;
   logic [TIME_W-1:0]     time_ff, time_in;
   logic [TIMEOUT_W-1:0]  timeout_ff;

   logic [6:0]            seq_mem  [SLOTS];
   logic [TAG_W-1:0]      tag_mem  [SLOTS];
   logic [TIME_W-1:0]     dl_mem   [SLOTS];

   logic                  ov_ff, ov_in;
   kind_type              okind_ff, okind_in;
   logic                  oacc_ff, oacc_in;
   logic [6:0]            oseq_ff, oseq_in;
   logic [2:0]            oslot_ff, oslot_in;
   logic [TAG_W-1:0]      otag_ff, otag_in;
   logic [7:0]            ostat_ff, ostat_in;
   logic                  odone_ff, odone_in;
   logic                  olast_ff, olast_in;

   logic                  out_free;
   logic                  free_found, hit_found, low_found;
   logic [SLOT_W-1:0]     free_idx, hit_idx, low_idx, rd_idx;
   logic [SLOTS-1:0]      rest_mask;
   logic [TIME_W-1:0]     diff;
   logic                  expired;
   logic [6:0]            req_id;
   logic                  req_ok;
   logic                  wr_en;
   logic [6:0]            rd_seq;
   logic [TAG_W-1:0]      rd_tag;

   assign out_free = ~ov_ff | rsp_tready;
   assign req_id   = {head.cmd.bcast, counter_ff};
   assign req_ok   = head.cmd.sent & (~head.cmd.track | free_found);

   always_comb begin
      free_found = 1'b0;
      free_idx   = '0;
      hit_found  = 1'b0;
      hit_idx    = '0;
      low_found  = 1'b0;
      low_idx    = '0;
      for (int i = 0; i < SLOTS; i++) begin
         if (!free_found && !active_ff[i]) begin
            free_found = 1'b1;
            free_idx   = SLOT_W'(i);
         end
         if (!hit_found && active_ff[i] && head.cmd.matchable &&
             seq_mem[i] == head.cmd.seq) begin
            hit_found = 1'b1;
            hit_idx   = SLOT_W'(i);
         end
         if (!low_found && mask_ff[i]) begin
            low_found = 1'b1;
            low_idx   = SLOT_W'(i);
         end
      end
      rest_mask = mask_ff;
      rest_mask[low_idx] = 1'b0;
   end

   assign rd_idx  = (state_ff == ST_DRAIN) ? low_idx : hit_idx;
   assign rd_seq  = seq_mem[rd_idx];
   assign rd_tag  = tag_mem[rd_idx];
   assign diff    = dl_mem[idx_ff] - time_ff;
   assign expired = active_ff[idx_ff] & ((diff == '0) | diff[TIME_W-1]);

   always_comb begin
      state_in   = state_ff;
      active_in  = active_ff;
      mask_in    = mask_ff;
      idx_in     = idx_ff;
      cnt_in     = cnt_ff;
      counter_in = counter_ff;
      time_in    = time_ff;
      q_pop      = 1'b0;
      wr_en      = 1'b0;
      ov_in      = ov_ff & ~rsp_tready;
      okind_in   = okind_ff;
      oacc_in    = oacc_ff;
      oseq_in    = oseq_ff;
      oslot_in   = oslot_ff;
      otag_in    = otag_ff;
      ostat_in   = ostat_ff;
      odone_in   = odone_ff;
      olast_in   = olast_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (head.valid && out_free) begin
               q_pop = 1'b1;
               unique case (head.cmd.op)
                  ACT_REQUEST: begin
                     ov_in    = 1'b1;
                     okind_in = KIND_OUTCOME;
                     oacc_in  = req_ok;
                     oseq_in  = req_id;
                     oslot_in = '0;
                     otag_in  = '0;
                     ostat_in = '0;
                     odone_in = 1'b0;
                     olast_in = 1'b1;
                     if (req_ok) begin
                        counter_in = counter_ff + 1'b1;
                        if (head.cmd.track) begin
                           wr_en               = 1'b1;
                           active_in[free_idx] = 1'b1;
                           oslot_in            = 3'(free_idx);
                           otag_in             = head.cmd.tag;
                        end
                     end
                  end
                  ACT_RESPONSE: begin
                     ov_in    = 1'b1;
                     oacc_in  = 1'b0;
                     olast_in = 1'b1;
                     if (hit_found) begin
                        okind_in = KIND_DELIVERED;
                        oseq_in  = rd_seq;
                        oslot_in = 3'(hit_idx);
                        otag_in  = rd_tag;
                        ostat_in = head.cmd.status;
                        odone_in = head.cmd.host;
                        if (head.cmd.host) begin
                           active_in[hit_idx] = 1'b0;
                        end
                     end else begin
                        okind_in = KIND_DISCARDED;
                        oseq_in  = '0;
                        oslot_in = '0;
                        otag_in  = '0;
                        ostat_in = '0;
                        odone_in = 1'b0;
                     end
                  end
                  ACT_TICK: begin
                     time_in  = time_ff + 1'b1;
                     idx_in   = '0;
                     mask_in  = '0;
                     state_in = ST_SCAN;
                  end
                  default: ;
               endcase
            end
         end
         ST_SCAN: begin
            mask_in[idx_ff] = expired;
            if (idx_ff == SLOT_W'(SLOTS - 1)) begin
               cnt_in   = '0;
               state_in = ST_DRAIN;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         ST_DRAIN: begin
            if (!low_found) begin
               state_in = ST_IDLE;
            end else if (out_free) begin
               ov_in              = 1'b1;
               okind_in           = KIND_TIMEOUT;
               oacc_in            = 1'b0;
               oseq_in            = rd_seq;
               oslot_in           = 3'(low_idx);
               otag_in            = rd_tag;
               ostat_in           = '0;
               odone_in           = 1'b1;
               olast_in           = (cnt_ff == CNT_W'(MAX_BURST - 1)) | (rest_mask == '0);
               active_in[low_idx] = 1'b0;
               mask_in            = rest_mask;
               cnt_in             = cnt_ff + 1'b1;
               if (olast_in) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         active_ff  <= '0;
         mask_ff    <= '0;
         idx_ff     <= '0;
         cnt_ff     <= '0;
         counter_ff <= '0;
         time_ff    <= '0;
         timeout_ff <= TIMEOUT_RESET;
         ov_ff      <= 1'b0;
      end else begin
         state_ff   <= state_in;
         active_ff  <= active_in;
         mask_ff    <= mask_in;
         idx_ff     <= idx_in;
         cnt_ff     <= cnt_in;
         counter_ff <= counter_in;
         time_ff    <= time_in;
         ov_ff      <= ov_in;
         if (csr_wen) begin
            timeout_ff <= csr_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      okind_ff <= okind_in;
      oacc_ff  <= oacc_in;
      oseq_ff  <= oseq_in;
      oslot_ff <= oslot_in;
      otag_ff  <= otag_in;
      ostat_ff <= ostat_in;
      odone_ff <= odone_in;
      olast_ff <= olast_in;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         seq_mem[free_idx] <= req_id;
         tag_mem[free_idx] <= head.cmd.tag;
         dl_mem[free_idx]  <= time_ff + {1'b0, timeout_ff};
      end
   end

   assign rsp_tvalid = ov_ff;
   assign rsp_tuser  = okind_ff;
   assign rsp_tlast  = olast_ff;
   assign rsp_tdata  = {4'b0, odone_ff, ostat_ff, otag_ff, oslot_ff, oseq_ff, oacc_ff};

endmodule

@@ rtl/request_transaction_tracker_unit.sv @@
// Request and response items: queued on acceptance, result registered as the item leaves
// the queue; one such item per cycle sustained unless the output stalls or a tick is busy.
// Tick items: the tick is taken, then a deadline scan of all SLOTS slots (one slot a cycle),
// then the timeout results, up to 8 per tick; no result is emitted if no slot expired.
// Synchronous active-high reset clears slot valid bits, sequence counter, time,
// the queue and the output valid flag; timeout_ticks returns to 20000.
module request_transaction_tracker_unit
   import rtt_pkg::*;
#(
   parameter int SLOTS = SLOTS_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_wen,
   input  logic [TIMEOUT_W-1:0]  csr_wdata,   // timeout_ticks
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // is_broadcast, wants_tracking, send_ok, context_tag[15:0], response_valid,
   // response_sequence[7:0], response_status[7:0], zero pad
   input  logic [REQ_DATA_W-1:0] req_tdata,
   input  logic [1:0]            req_tuser,   // action
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // accepted, sequence_id[6:0], slot_index[2:0], tag_out[15:0], status_out[7:0],
   // complete, zero pad
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   output logic [1:0]            rsp_tuser,   // kind
   output logic                  rsp_tlast    // last
);

   logic          q_full;
   logic          q_push;
   cmd_type       q_cmd;
   queue_out_type q_head;
   logic          q_pop;

   rtt_front u_front (
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .q_full     (q_full),
      .q_push     (q_push),
      .q_cmd      (q_cmd)
   );

   rtt_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_cmd (q_cmd),
      .full     (q_full),
      .head     (q_head),
      .pop      (q_pop)
   );

   rtt_back #(
      .SLOTS (SLOTS)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .csr_wen    (csr_wen),
      .csr_wdata  (csr_wdata),
      .head       (q_head),
      .q_pop      (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

@@ rtl/rtt_checker.sv @@
module rtt_checker
   import rtt_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [RSP_DATA_W-1:0] rsp_tdata,
   input logic [1:0]            rsp_tuser,
   input logic                  rsp_tlast
);

   // request outcomes and response results are single items
   a_single_last : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser == KIND_OUTCOME || rsp_tuser == KIND_DELIVERED ||
                     rsp_tuser == KIND_DISCARDED) |-> rsp_tlast)
      else $error("single-result item without last");

   a_discard_zero : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == KIND_DISCARDED |-> rsp_tdata == '0)
      else $error("discarded response carries data");

   a_timeout_done : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == KIND_TIMEOUT |->
         rsp_tdata[35] && !rsp_tdata[0] && rsp_tdata[34:27] == 8'h00)
      else $error("timeout item malformed");

   a_hold : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) &&
         $stable(rsp_tuser) && $stable(rsp_tlast))
      else $error("stalled item changed");

endmodule

bind request_transaction_tracker_unit rtt_checker u_rtt_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);
